/* design/spgr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spgr_pkg
// Codes and shared types of the series-parallel graph reducer.
// ----------------------------------------------------------------------------
package spgr_pkg;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_ADD   = 2'd1;

   localparam logic [2:0] ST_EMPTY       = 3'd0;
   localparam logic [2:0] ST_BUILT       = 3'd1;
   localparam logic [2:0] ST_BUILD_ERROR = 3'd2;
   localparam logic [2:0] ST_SERIES      = 3'd3;
   localparam logic [2:0] ST_PARALLEL    = 3'd4;
   localparam logic [2:0] ST_FULL        = 3'd5;
   localparam logic [2:0] ST_STUCK       = 3'd6;

   typedef struct packed {
      logic clear;
      logic en;
      logic we;
   } mem_ctl_type;

endpackage

/* design/spgr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spgr_if
// Request and response channels of the series-parallel graph reducer.
// ----------------------------------------------------------------------------
interface spgr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [5:0] from_vertex;
   logic [5:0] to_vertex;

   modport source (output valid, action, from_vertex, to_vertex, input ready);
   modport sink (input valid, action, from_vertex, to_vertex, output ready);
endinterface

interface spgr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [4:0] kept_vertex;
   logic [4:0] removed_vertex;

   modport source (output valid, status, kept_vertex, removed_vertex, input ready);
   modport sink (input valid, status, kept_vertex, removed_vertex, output ready);
endinterface

/* design/series_parallel_graph_reducer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// series_parallel_graph_reducer_top
// Series-parallel reduction of a directed graph held as a bit matrix.
// ----------------------------------------------------------------------------
// The graph lives in two single-port memories, one of successor rows and one
// of predecessor columns, and one beat is processed at a time. An added edge
// is set by a read and a write-back of both memories. A reduction step scans
// the vertices in turn for a series merge, then tries each parallel candidate
// and a parallel merge, and a step that finds nothing checks every vertex for
// remaining edges. A finished response waits in an output register while the
// next request beat is taken.
// ----------------------------------------------------------------------------
module series_parallel_graph_reducer_top #(
   parameter int VERTICES = 32
) (
   input  logic          clock,
   input  logic          reset,
   spgr_req_if.sink      req_chan,
   spgr_rsp_if.source    rsp_chan
);

   localparam int AW = $clog2(VERTICES);
   localparam logic [AW-1:0] LAST = AW'(VERTICES - 1);
   localparam logic [VERTICES-1:0] ONE = {{(VERTICES - 1){1'b0}}, 1'b1};

   typedef enum logic [15:0] {
      S_IDLE     = 16'b0000_0000_0000_0001,
      S_ADD_RD   = 16'b0000_0000_0000_0010,
      S_ADD_WR   = 16'b0000_0000_0000_0100,
      S_SCAN_RD  = 16'b0000_0000_0000_1000,
      S_SCAN_CHK = 16'b0000_0000_0001_0000,
      S_SER_CHK  = 16'b0000_0000_0010_0000,
      S_SER_K    = 16'b0000_0000_0100_0000,
      S_SER_KW   = 16'b0000_0000_1000_0000,
      S_PAR_RD   = 16'b0000_0001_0000_0000,
      S_PAR_CHK  = 16'b0000_0010_0000_0000,
      S_PAR_K    = 16'b0000_0100_0000_0000,
      S_PAR_KW   = 16'b0000_1000_0000_0000,
      S_ZERO     = 16'b0001_0000_0000_0000,
      S_ANY_RD   = 16'b0010_0000_0000_0000,
      S_ANY_CHK  = 16'b0100_0000_0000_0000,
      S_RESP     = 16'b1000_0000_0000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [AW-1:0]       vi_ff, vi_in, vj_ff, vj_in, k_ff, k_in;
   logic [AW-1:0]       from_ff, from_in, to_ff, to_in;
   logic [VERTICES-1:0] ri_ff, ri_in, ci_ff, ci_in, rv_ff, rv_in, cv_ff, cv_in;
   logic                any_ff, any_in;
   logic [2:0]          pend_status_ff, pend_status_in;
   logic [4:0]          pend_kept_ff, pend_kept_in, pend_removed_ff, pend_removed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [4:0]          rsp_kept_ff, rsp_kept_in, rsp_removed_ff, rsp_removed_in;

   spgr_pkg::mem_ctl_type row_ctl, col_ctl;
   logic [AW-1:0]         row_addr, col_addr;
   logic [VERTICES-1:0]   row_wdata, col_wdata, row_rdata, col_rdata;

   logic                  req_fire, rsp_free, range_bad;
   logic [AW-1:0]         low_idx;

   spgr_bitmem #(.VERTICES(VERTICES)) u_rows (
      .clock (clock), .reset (reset), .ctl (row_ctl),
      .addr (row_addr), .wdata (row_wdata), .rdata (row_rdata)
   );

   spgr_bitmem #(.VERTICES(VERTICES)) u_cols (
      .clock (clock), .reset (reset), .ctl (col_ctl),
      .addr (col_addr), .wdata (col_wdata), .rdata (col_rdata)
   );

   function automatic logic one_bit(input logic [VERTICES-1:0] x);
      return (x != '0) && ((x & (x - ONE)) == '0);
   endfunction

   always_comb begin
      low_idx = '0;
      for (int i = VERTICES - 1; i >= 0; i--) begin
         if (row_rdata[i]) begin
            low_idx = AW'(i);
         end
      end
   end

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign range_bad = ({1'b0, req_chan.from_vertex} >= 7'(VERTICES))
                   || ({1'b0, req_chan.to_vertex} >= 7'(VERTICES));

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.kept_vertex  = rsp_kept_ff;
   assign rsp_chan.removed_vertex = rsp_removed_ff;

   always_comb begin
      state_in        = state_ff;
      vi_in           = vi_ff;
      vj_in           = vj_ff;
      k_in            = k_ff;
      from_in         = from_ff;
      to_in           = to_ff;
      ri_in           = ri_ff;
      ci_in           = ci_ff;
      rv_in           = rv_ff;
      cv_in           = cv_ff;
      any_in          = any_ff;
      pend_status_in  = pend_status_ff;
      pend_kept_in    = pend_kept_ff;
      pend_removed_in = pend_removed_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_kept_in     = rsp_kept_ff;
      rsp_removed_in  = rsp_removed_ff;
      row_ctl         = '0;
      col_ctl         = '0;
      row_addr        = vi_ff;
      col_addr        = vi_ff;
      row_wdata       = '0;
      col_wdata       = '0;

      unique case (state_ff) inside
         S_IDLE: begin
            pend_kept_in    = '0;
            pend_removed_in = '0;
            if (req_fire) begin
               from_in = req_chan.from_vertex[AW-1:0];
               to_in   = req_chan.to_vertex[AW-1:0];
               if (req_chan.action == spgr_pkg::ACT_CLEAR) begin
                  row_ctl.clear  = 1'b1;
                  col_ctl.clear  = 1'b1;
                  pend_status_in = spgr_pkg::ST_EMPTY;
                  state_in       = S_RESP;
               end else if (req_chan.action == spgr_pkg::ACT_ADD) begin
                  if (range_bad) begin
                     row_ctl.clear  = 1'b1;
                     col_ctl.clear  = 1'b1;
                     pend_status_in = spgr_pkg::ST_BUILD_ERROR;
                     state_in       = S_RESP;
                  end else begin
                     state_in = S_ADD_RD;
                  end
               end else begin
                  vi_in    = '0;
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_ADD_RD: begin
            row_ctl.en = 1'b1;
            col_ctl.en = 1'b1;
            row_addr   = from_ff;
            col_addr   = to_ff;
            state_in   = S_ADD_WR;
         end
         S_ADD_WR: begin
            row_ctl.en     = 1'b1;
            row_ctl.we     = 1'b1;
            col_ctl.en     = 1'b1;
            col_ctl.we     = 1'b1;
            row_addr       = from_ff;
            col_addr       = to_ff;
            row_wdata      = row_rdata | (ONE << to_ff);
            col_wdata      = col_rdata | (ONE << from_ff);
            pend_status_in = spgr_pkg::ST_BUILT;
            state_in       = S_RESP;
         end
         S_SCAN_RD: begin
            row_ctl.en = 1'b1;
            col_ctl.en = 1'b1;
            state_in   = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            ri_in = row_rdata;
            ci_in = col_rdata;
            if (one_bit(row_rdata)) begin
               vj_in      = low_idx;
               row_ctl.en = 1'b1;
               col_ctl.en = 1'b1;
               row_addr   = low_idx;
               col_addr   = low_idx;
               state_in   = S_SER_CHK;
            end else if (vi_ff == LAST) begin
               k_in     = '0;
               any_in   = 1'b0;
               state_in = S_ANY_RD;
            end else begin
               vi_in    = vi_ff + AW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_SER_CHK: begin
            if (one_bit(col_rdata)) begin
               row_ctl.en     = 1'b1;
               row_ctl.we     = 1'b1;
               row_wdata      = row_rdata;
               rv_in          = row_rdata;
               k_in           = '0;
               pend_status_in = spgr_pkg::ST_SERIES;
               state_in       = S_SER_K;
            end else begin
               vj_in    = '0;
               state_in = S_PAR_RD;
            end
         end
         S_SER_K, S_SER_KW: begin
            col_addr = k_ff;
            if (state_ff == S_SER_K && rv_ff[k_ff]) begin
               col_ctl.en = 1'b1;
               state_in   = S_SER_KW;
            end else begin
               if (state_ff == S_SER_KW) begin
                  col_ctl.en = 1'b1;
                  col_ctl.we = 1'b1;
                  col_wdata  = (col_rdata | (ONE << vi_ff)) & ~(ONE << vj_ff);
               end
               if (k_ff == LAST) begin
                  state_in = S_ZERO;
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = S_SER_K;
               end
            end
         end
         S_PAR_RD: begin
            row_addr = vj_ff;
            col_addr = vj_ff;
            if (vj_ff != vi_ff) begin
               row_ctl.en = 1'b1;
               col_ctl.en = 1'b1;
               state_in   = S_PAR_CHK;
            end else if (vj_ff != LAST) begin
               vj_in = vj_ff + AW'(1);
            end else if (vi_ff == LAST) begin
               k_in     = '0;
               any_in   = 1'b0;
               state_in = S_ANY_RD;
            end else begin
               vi_in    = vi_ff + AW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_PAR_CHK: begin
            if (row_rdata == ri_ff && col_rdata == ci_ff) begin
               rv_in          = row_rdata;
               cv_in          = col_rdata;
               k_in           = '0;
               pend_status_in = spgr_pkg::ST_PARALLEL;
               state_in       = S_PAR_K;
            end else if (vj_ff != LAST) begin
               vj_in    = vj_ff + AW'(1);
               state_in = S_PAR_RD;
            end else if (vi_ff == LAST) begin
               k_in     = '0;
               any_in   = 1'b0;
               state_in = S_ANY_RD;
            end else begin
               vi_in    = vi_ff + AW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_PAR_K, S_PAR_KW: begin
            row_addr = k_ff;
            col_addr = k_ff;
            if (state_ff == S_PAR_K && (rv_ff[k_ff] || cv_ff[k_ff])) begin
               col_ctl.en = rv_ff[k_ff];
               row_ctl.en = cv_ff[k_ff];
               state_in   = S_PAR_KW;
            end else begin
               if (state_ff == S_PAR_KW) begin
                  col_ctl.en = rv_ff[k_ff];
                  col_ctl.we = rv_ff[k_ff];
                  row_ctl.en = cv_ff[k_ff];
                  row_ctl.we = cv_ff[k_ff];
                  col_wdata  = col_rdata & ~(ONE << vj_ff);
                  row_wdata  = row_rdata & ~(ONE << vj_ff);
               end
               if (k_ff == LAST) begin
                  state_in = S_ZERO;
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = S_PAR_K;
               end
            end
         end
         S_ZERO: begin
            row_ctl.en      = 1'b1;
            row_ctl.we      = 1'b1;
            col_ctl.en      = 1'b1;
            col_ctl.we      = 1'b1;
            row_addr        = vj_ff;
            col_addr        = vj_ff;
            pend_kept_in    = 5'(vi_ff);
            pend_removed_in = 5'(vj_ff);
            state_in        = S_RESP;
         end
         S_ANY_RD: begin
            row_ctl.en = 1'b1;
            col_ctl.en = 1'b1;
            row_addr   = k_ff;
            col_addr   = k_ff;
            state_in   = S_ANY_CHK;
         end
         S_ANY_CHK: begin
            any_in = any_ff || (row_rdata != '0) || (col_rdata != '0);
            if (k_ff == LAST) begin
               pend_status_in = any_in ? spgr_pkg::ST_STUCK : spgr_pkg::ST_FULL;
               state_in       = S_RESP;
            end else begin
               k_in     = k_ff + AW'(1);
               state_in = S_ANY_RD;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = pend_status_ff;
               rsp_kept_in    = pend_kept_ff;
               rsp_removed_in = pend_removed_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vi_ff           <= vi_in;
      vj_ff           <= vj_in;
      k_ff            <= k_in;
      from_ff         <= from_in;
      to_ff           <= to_in;
      ri_ff           <= ri_in;
      ci_ff           <= ci_in;
      rv_ff           <= rv_in;
      cv_ff           <= cv_in;
      any_ff          <= any_in;
      pend_status_ff  <= pend_status_in;
      pend_kept_ff    <= pend_kept_in;
      pend_removed_ff <= pend_removed_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_kept_ff     <= rsp_kept_in;
      rsp_removed_ff  <= rsp_removed_in;
   end

`ifndef SYNTHESIS
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("request beat accepted but controller stayed idle");

   a_vertices_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != spgr_pkg::ST_SERIES
       && rsp_status_ff != spgr_pkg::ST_PARALLEL)
      |-> (rsp_kept_ff == '0 && rsp_removed_ff == '0))
      else $error("vertex numbers reported with a non-reduction status");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_status_ff <= spgr_pkg::ST_STUCK)
      else $error("response status out of range");
`endif

endmodule

/* design/spgr_bitmem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spgr_bitmem
// Single-port bit-matrix memory with a registered read and per-entry
// valid bits, so that one clear strobe clears the whole matrix.
// ----------------------------------------------------------------------------
module spgr_bitmem #(
   parameter int VERTICES = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  spgr_pkg::mem_ctl_type       ctl,
   input  logic [$clog2(VERTICES)-1:0] addr,
   input  logic [VERTICES-1:0]         wdata,
   output logic [VERTICES-1:0]         rdata
);

   logic [VERTICES-1:0] mem [VERTICES];
   logic [VERTICES-1:0] valid_ff;
   logic [VERTICES-1:0] rd_ff;
   logic                rvalid_ff;

   always_ff @(posedge clock) begin
      if (ctl.en && ctl.we) begin
         mem[addr] <= wdata;
      end
      if (ctl.en && !ctl.we) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else if (ctl.en) begin
         if (ctl.we) begin
            valid_ff[addr] <= 1'b1;
         end else begin
            rvalid_ff <= valid_ff[addr];
         end
      end
   end

   assign rdata = rvalid_ff ? rd_ff : '0;

endmodule
